### rtl/chmc_pkg.sv
`timescale 1ns / 1ps
package chmc_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_HULL_RD,
        ST_HULL_MUL,
        ST_HULL_CMP,
        ST_HULL_WAIT,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_PUSH
    } hull_state_t;
endpackage

### rtl/chmc_front.sv
`timescale 1ns / 1ps
// Front: registers accepted points into a short queue.
module chmc_front #(
    parameter int COORD_BITS = chmc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    output logic                         q_valid,
    input  logic                         q_take,
    output logic signed [COORD_BITS-1:0] q_x,
    output logic signed [COORD_BITS-1:0] q_y,
    output logic                         q_last
);
    localparam int W = 2 * COORD_BITS + 1;
    logic [W-1:0] slot_reg [chmc_pkg::QUEUE_DEPTH];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         do_push;

    assign full    = (cnt_reg == 2'(chmc_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign {q_x, q_y, q_last} = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= {point_x, point_y, last_point};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_take && q_valid)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(q_take && q_valid);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(chmc_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !(q_take && q_valid)) |=> q_valid)
        else $error("pushed entry not visible");
    assert property (@(posedge clk) disable iff (!rst_n) !(q_take && !q_valid))
        else $error("take from empty queue");
endmodule

### rtl/chmc_back.sv
`timescale 1ns / 1ps
// Back: store, insertion sort, monotone chain, output.
module chmc_back #(
    parameter int MAX_POINTS = chmc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chmc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_take,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    input  logic                         q_last,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y,
    output logic                         last_vertex,
    output logic                         overflow
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int PBW = 2 * COORD_BITS;

    logic [PBW-1:0] pts_mem [MAX_POINTS];
    logic [AW-1:0]  stk_mem [MAX_POINTS + 1];

    chmc_pkg::hull_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] lower_reg, lower_next;
    logic          upper_reg, upper_next;
    logic [CW-1:0] k_reg, k_next;
    logic [PBW-1:0] key_reg, key_next;
    logic [PBW-1:0] prd_reg, p1_reg;
    logic [AW-1:0]  s0_reg, s1_reg;
    logic signed [PW-1:0] m1_reg, m2_reg;

    logic          ov_valid_reg;
    logic [PBW-1:0] ov_pt_reg;
    logic          ov_last_reg, ov_ovf_reg;

    logic          pw_en;
    logic [AW-1:0] pw_addr, pr_addr, pr2_addr;
    logic [PBW-1:0] pw_data;
    logic          sw_en;
    logic [AW-1:0] sw_data;
    logic [CW-1:0] sw_addr;
    logic [CW-1:0] sr_addr;
    logic          ov_load;
    logic [CW-1:0] fl;

    assign empty = !ov_valid_reg;
    assign vertex_x = ov_pt_reg[PBW-1:COORD_BITS];
    assign vertex_y = ov_pt_reg[COORD_BITS-1:0];
    assign last_vertex = ov_last_reg;
    assign overflow = ov_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            pts_mem[pw_addr] <= pw_data;
        end
        prd_reg <= pts_mem[pr_addr];
        p1_reg  <= pts_mem[pr2_addr];
        if (sw_en)
        begin
            stk_mem[sw_addr] <= sw_data;
        end
        s0_reg <= stk_mem[sr_addr];
        s1_reg <= stk_mem[sp_reg - CW'(1)];
    end

    // cross-product operands: prd = o, p1 = a, key = new point
    logic signed [DW-1:0] ax, ay, bx, by;
    always_comb
    begin
        ax = DW'($signed(p1_reg[PBW-1:COORD_BITS])) - DW'($signed(prd_reg[PBW-1:COORD_BITS]));
        ay = DW'($signed(p1_reg[COORD_BITS-1:0])) - DW'($signed(prd_reg[COORD_BITS-1:0]));
        bx = DW'($signed(key_reg[PBW-1:COORD_BITS])) - DW'($signed(prd_reg[PBW-1:COORD_BITS]));
        by = DW'($signed(key_reg[COORD_BITS-1:0])) - DW'($signed(prd_reg[COORD_BITS-1:0]));
    end

    logic sort_gt;
    always_comb
    begin
        if ($signed(prd_reg[PBW-1:COORD_BITS]) == $signed(key_reg[PBW-1:COORD_BITS]))
        begin
            sort_gt = $signed(prd_reg[COORD_BITS-1:0]) > $signed(key_reg[COORD_BITS-1:0]);
        end
        else
        begin
            sort_gt = $signed(prd_reg[PBW-1:COORD_BITS]) > $signed(key_reg[PBW-1:COORD_BITS]);
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= PW'(ax) * PW'(by);
        m2_reg <= PW'(ay) * PW'(bx);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        i_next = i_reg;
        j_next = j_reg;
        sp_next = sp_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        k_next = k_reg;
        key_next = key_reg;
        q_take = 1'b0;
        pw_en = 1'b0;
        pw_addr = AW'(cnt_reg);
        pw_data = {q_x, q_y};
        pr_addr = AW'(j_reg - CW'(1));
        pr2_addr = s1_reg;
        sw_en = 1'b0;
        sw_addr = sp_reg;
        sw_data = AW'(i_reg);
        sr_addr = sp_reg - CW'(2);
        ov_load = 1'b0;
        fl = upper_reg ? lower_reg - CW'(1) : CW'(0);
        case (state_reg)
            chmc_pkg::ST_LOAD:
            begin
                q_take = q_valid;
                if (q_valid)
                begin
                    if (cnt_reg < CW'(MAX_POINTS))
                    begin
                        pw_en = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (q_last)
                    begin
                        k_next = CW'(0);
                        if (cnt_next < CW'(3))
                        begin
                            i_next = CW'(0);
                            state_next = chmc_pkg::ST_OUT_RD;
                        end
                        else
                        begin
                            i_next = CW'(1);
                            state_next = chmc_pkg::ST_SORT_RD;
                            pr_addr = AW'(1);
                        end
                    end
                end
            end
            // insertion sort: key held, shift larger entries up
            chmc_pkg::ST_SORT_RD:
            begin
                pr_addr = AW'(i_reg);
                j_next = i_reg;
                state_next = chmc_pkg::ST_SORT_WR;
            end
            chmc_pkg::ST_SORT_WR:
            begin
                key_next = prd_reg;
                pr_addr = AW'(j_reg - CW'(1));
                state_next = chmc_pkg::ST_SORT_CMP;
            end
            chmc_pkg::ST_SORT_CMP:
            begin
                if (j_reg != CW'(0) && sort_gt)
                begin
                    pw_en = 1'b1;
                    pw_addr = AW'(j_reg);
                    pw_data = prd_reg;
                    j_next = j_reg - CW'(1);
                    pr_addr = AW'(j_reg - CW'(2));
                end
                else
                begin
                    pw_en = 1'b1;
                    pw_addr = AW'(j_reg);
                    pw_data = key_reg;
                    if (i_reg + CW'(1) < cnt_reg)
                    begin
                        i_next = i_reg + CW'(1);
                        state_next = chmc_pkg::ST_SORT_RD;
                    end
                    else
                    begin
                        i_next = CW'(0);
                        sp_next = CW'(0);
                        upper_next = 1'b0;
                        state_next = chmc_pkg::ST_HULL_WAIT;
                    end
                end
            end
            // pop test: read point i, then o and a, multiply, compare
            chmc_pkg::ST_HULL_RD:
            begin
                key_next = prd_reg;
                pr_addr = s0_reg;
                if (sp_reg >= fl + CW'(2) && sp_reg >= CW'(2))
                begin
                    state_next = chmc_pkg::ST_HULL_MUL;
                end
                else
                begin
                    state_next = chmc_pkg::ST_HULL_CMP;
                end
            end
            chmc_pkg::ST_HULL_MUL:
            begin
                pr_addr = s0_reg;
                state_next = chmc_pkg::ST_HULL_CMP;
                k_next = CW'(1);
            end
            chmc_pkg::ST_HULL_CMP:
            begin
                if (k_reg == CW'(1) && sp_reg >= fl + CW'(2) && sp_reg >= CW'(2)
                    && m1_reg - m2_reg <= 0)
                begin
                    sp_next = sp_reg - CW'(1);
                    k_next = CW'(2);
                    pr_addr = AW'(i_reg);
                    state_next = chmc_pkg::ST_HULL_WAIT;
                end
                else if (k_reg == CW'(0) || k_reg == CW'(1))
                begin
                    k_next = CW'(0);
                    sw_en = 1'b1;
                    sp_next = sp_reg + CW'(1);
                    if (!upper_reg)
                    begin
                        if (i_reg + CW'(1) < cnt_reg)
                        begin
                            i_next = i_reg + CW'(1);
                        end
                        else
                        begin
                            upper_next = 1'b1;
                            lower_next = sp_reg + CW'(1);
                            i_next = cnt_reg - CW'(2);
                        end
                        pr_addr = AW'(i_next);
                        state_next = chmc_pkg::ST_HULL_WAIT;
                    end
                    else if (i_reg != CW'(0))
                    begin
                        i_next = i_reg - CW'(1);
                        pr_addr = AW'(i_next);
                        state_next = chmc_pkg::ST_HULL_WAIT;
                    end
                    else
                    begin
                        i_next = CW'(0);
                        sp_next = sp_reg;
                        state_next = chmc_pkg::ST_OUT_RD;
                    end
                end
                else
                begin
                    state_next = chmc_pkg::ST_OUT_RD;
                end
            end
            // settle stack reads before the next pop test
            chmc_pkg::ST_HULL_WAIT:
            begin
                pr_addr = AW'(i_reg);
                k_next = CW'(0);
                state_next = chmc_pkg::ST_HULL_RD;
            end
            // output: stack entry, then point, then hand over
            chmc_pkg::ST_OUT_RD:
            begin
                sr_addr = i_reg;
                k_next = (cnt_reg >= CW'(3)) ? sp_reg : cnt_reg;
                state_next = chmc_pkg::ST_OUT_WAIT;
            end
            chmc_pkg::ST_OUT_WAIT:
            begin
                sr_addr = i_reg;
                pr_addr = (cnt_reg >= CW'(3)) ? s0_reg : AW'(i_reg);
                state_next = chmc_pkg::ST_OUT_PUSH;
            end
            chmc_pkg::ST_OUT_PUSH:
            begin
                sr_addr = i_reg;
                pr_addr = (cnt_reg >= CW'(3)) ? s0_reg : AW'(i_reg);
                if (i_reg >= k_reg)
                begin
                    cnt_next = CW'(0);
                    ovf_next = 1'b0;
                    sp_next = CW'(0);
                    state_next = chmc_pkg::ST_LOAD;
                end
                else if (!ov_valid_reg || pop)
                begin
                    ov_load = 1'b1;
                    i_next = i_reg + CW'(1);
                    state_next = chmc_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = chmc_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chmc_pkg::ST_LOAD;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            sp_reg <= '0;
            lower_reg <= '0;
            upper_reg <= 1'b0;
            k_reg <= '0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            i_reg <= i_next;
            j_reg <= j_next;
            sp_reg <= sp_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            k_reg <= k_next;
            if (ov_load)
            begin
                ov_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ov_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ov_load)
        begin
            ov_pt_reg <= prd_reg;
            ov_last_reg <= (i_reg + CW'(1) == k_reg);
            ov_ovf_reg <= ovf_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= CW'(MAX_POINTS + 1))
        else $error("hull stack overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_take && state_reg != chmc_pkg::ST_LOAD) |-> 1'b0)
        else $error("point taken outside load");
endmodule

### rtl/convex_hull_monotone_chain.sv
`timescale 1ns / 1ps
// Convex hull by monotone chain. Points load one per cycle through a two-entry
// queue; the transaction with last_point closes the set, and input stalls until
// all vertices of that set have been handed over. The back end then
// insertion-sorts the stored points by x, then y, builds lower and upper hulls
// (each pop test reads point i and the top two stack entries, multiplies, then
// compares), and emits vertices through an output register, loading the next
// one when the register is empty or being popped, then returns to loading.
// Up to MAX_POINTS points are kept; more set overflow on every vertex of that
// set. Sets of under three points return in arrival order.
module convex_hull_monotone_chain #(
    parameter int MAX_POINTS = chmc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chmc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] vertex_x,
    output logic signed [COORD_BITS-1:0] vertex_y,
    output logic                         last_vertex,
    output logic                         overflow
);
    logic q_valid, q_take, q_last;
    logic signed [COORD_BITS-1:0] q_x, q_y;

    chmc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk, .rst_n, .push, .full, .point_x, .point_y, .last_point,
        .q_valid, .q_take, .q_x, .q_y, .q_last
    );

    chmc_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_take, .q_x, .q_y, .q_last,
        .empty, .pop, .vertex_x, .vertex_y, .last_vertex, .overflow
    );
endmodule
